### rtl/spc_pkg.sv
// Shared types and constants of the status panel controller.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package spc_pkg;

   // Beep pattern store geometry.
   localparam int PATTERN_DEPTH = 10;
   localparam int PAT_LEN_W     = $clog2(PATTERN_DEPTH + 1);
   localparam int PAT_IDX_W     = $clog2(PATTERN_DEPTH);
   localparam int PAT_PAIRS     = PATTERN_DEPTH / 2;

   // Saturation limits of the tick counters.
   localparam logic [15:0] TICK_MAX = 16'hFFFF;
   localparam logic [9:0]  HOLD_MAX = 10'h3FF;

   // Reset pattern: three short beeps with the reset tone and gap lengths.
   localparam logic [8:0] RESET_SHORT_TONE = 9'd100;
   localparam logic [8:0] RESET_LONG_TONE  = 9'd300;
   localparam logic [8:0] RESET_TONE_GAP   = 9'd30;
   localparam int         RESET_BEEPS      = 3;

   // Configuration port.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISCONNECT_TIMEOUT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHORD_HOLD         = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINGLE_HOLD        = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_TONE         = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_TONE          = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_GAP           = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_BLINK         = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_BLINK         = 4'd7;

   // Run status as reported by the host.
   typedef enum logic [2:0] {
      STATUS_IDLE    = 3'd0,
      STATUS_RUN_A   = 3'd1,
      STATUS_RUN_B   = 3'd2,
      STATUS_STOPPED = 3'd3,
      STATUS_ERROR   = 3'd4
   } run_status_type;

   // Command sent to the host.
   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_STOP    = 2'd1,
      CMD_START_A = 2'd2,
      CMD_START_B = 2'd3
   } host_cmd_type;

   // Lamp bit positions inside the lamp vector.
   localparam int LAMP_G_BIT = 0;
   localparam int LAMP_R_BIT = 1;
   localparam int LAMP_Y_BIT = 2;

   // Configuration register file contents.
   typedef struct packed {
      logic [15:0] disconnect_timeout;
      logic [9:0]  chord_hold;
      logic [9:0]  single_hold;
      logic [8:0]  short_tone;
      logic [8:0]  long_tone;
      logic [8:0]  tone_gap;
      logic [9:0]  fast_blink;
      logic [9:0]  slow_blink;
   } cfg_type;

   // Control from the panel logic to the beeper.
   typedef struct packed {
      logic       load;    // load a new beep pattern
      logic [1:0] nshort;  // short beeps in the new pattern
      logic [1:0] nlong;   // long beeps after the short ones
      logic       toggle;  // flip the buzzer after the pattern step
   } beep_ctrl_type;

endpackage

`default_nettype wire

### rtl/status_panel_controller.sv
// Status panel controller: one request is one millisecond tick of the panel. Each
// request carries the decoded host message and the two button levels, and gives one
// response with the buzzer and lamp levels, the link flag and the host command. A
// request can be taken every clock cycle while the response channel is not stalled; a
// taken request waits in the input register before the state and result registers
// update, and a stalled response holds the next request in the input register, which
// then stalls further requests. Configuration writes are always ready and are meant for
// an idle block.
// Depends on spc_pkg, spc_csr, spc_panel and spc_beeper.
`default_nettype none

module status_panel_controller (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel.
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_message_valid,
   input  wire logic [2:0]                      req_message_code,
   input  wire logic                            req_green_pressed,
   input  wire logic                            req_yellow_pressed,
   // Response channel.
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_buzzer_on,
   output logic                                 rsp_lamp_green,
   output logic                                 rsp_lamp_red,
   output logic                                 rsp_lamp_yellow,
   output logic                                 rsp_link_up,
   output logic [1:0]                           rsp_host_command,
   // Configuration channel.
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [spc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [spc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import spc_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic          msg_valid_ff;
   logic [2:0]    msg_code_ff;
   logic          green_ff;
   logic          yellow_ff;
   logic          out_valid_ff, out_valid_in;
   logic          advance;
   logic          accept;
   cfg_type       cfg;
   beep_ctrl_type beep_ctrl;
   logic [2:0]    lamp_levels;

   // The held request moves into the state when the result register is free.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         msg_valid_ff <= req_message_valid;
         msg_code_ff  <= req_message_code;
         green_ff     <= req_green_pressed;
         yellow_ff    <= req_yellow_pressed;
      end
   end

   spc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   spc_panel u_panel (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .cfg            (cfg),
      .message_valid  (msg_valid_ff),
      .message_code   (msg_code_ff),
      .green_pressed  (green_ff),
      .yellow_pressed (yellow_ff),
      .beep_ctrl      (beep_ctrl),
      .lamp_levels    (lamp_levels),
      .link_up        (rsp_link_up),
      .host_command   (rsp_host_command)
   );

   spc_beeper u_beeper (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .cfg          (cfg),
      .beep_ctrl    (beep_ctrl),
      .buzzer_level (rsp_buzzer_on)
   );

   // The state registers hold the last response until the next request advances.
   assign rsp_valid       = out_valid_ff;
   assign rsp_lamp_green  = lamp_levels[LAMP_G_BIT];
   assign rsp_lamp_red    = lamp_levels[LAMP_R_BIT];
   assign rsp_lamp_yellow = lamp_levels[LAMP_Y_BIT];

endmodule

`default_nettype wire

### rtl/spc_csr.sv
// Configuration register file of the status panel controller.
// Depends on spc_pkg for the register indexes and the cfg_type layout.
`default_nettype none

module spc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [spc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [spc_pkg::CSR_DATA_W-1:0]  csr_data,
   output spc_pkg::cfg_type                    cfg
);
   import spc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register decode; unknown indexes leave the file unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DISCONNECT_TIMEOUT: cfg_in.disconnect_timeout = csr_data;
            CSR_CHORD_HOLD:         cfg_in.chord_hold  = csr_data[9:0];
            CSR_SINGLE_HOLD:        cfg_in.single_hold = csr_data[9:0];
            CSR_SHORT_TONE:         cfg_in.short_tone  = csr_data[8:0];
            CSR_LONG_TONE:          cfg_in.long_tone   = csr_data[8:0];
            CSR_TONE_GAP:           cfg_in.tone_gap    = csr_data[8:0];
            CSR_FAST_BLINK:         cfg_in.fast_blink  = csr_data[9:0];
            CSR_SLOW_BLINK:         cfg_in.slow_blink  = csr_data[9:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disconnect_timeout <= 16'd1000;
         cfg_ff.chord_hold         <= 10'd100;
         cfg_ff.single_hold        <= 10'd500;
         cfg_ff.short_tone         <= RESET_SHORT_TONE;
         cfg_ff.long_tone          <= RESET_LONG_TONE;
         cfg_ff.tone_gap           <= RESET_TONE_GAP;
         cfg_ff.fast_blink         <= 10'd100;
         cfg_ff.slow_blink         <= 10'd500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/spc_beeper.sv
// Beep pattern store and tone player of the status panel controller.
// Depends on spc_pkg for the store geometry and the beeper control struct.
`default_nettype none

module spc_beeper (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  spc_pkg::cfg_type           cfg,
   input  spc_pkg::beep_ctrl_type     beep_ctrl,
   output logic                       buzzer_level
);
   import spc_pkg::*;

   logic [8:0]           store_ff [PATTERN_DEPTH];
   logic [8:0]           store_in [PATTERN_DEPTH];
   logic [PAT_LEN_W-1:0] len_ff, len_in;
   logic [PAT_LEN_W-1:0] pos_ff, pos_in;
   logic [15:0]          tone_ff, tone_in;
   logic                 buzz_ff, buzz_in;

   logic [2:0]           total;
   logic [PAT_LEN_W-1:0] pairs;
   logic [PAT_LEN_W-1:0] pos_ld;
   logic [15:0]          tone_ld;
   logic [8:0]           entry;

   assign buzzer_level = buzz_ff;

   // Pattern load, then one tick of the tone and gap sequencer.
   always_comb begin
      store_in = store_ff;
      len_in   = len_ff;
      pos_ld   = pos_ff;
      tone_ld  = tone_ff;
      total    = {1'b0, beep_ctrl.nshort} + {1'b0, beep_ctrl.nlong};
      pairs    = (int'(total) < PAT_PAIRS) ? PAT_LEN_W'(total) : PAT_LEN_W'(PAT_PAIRS);
      if (beep_ctrl.load) begin
         for (int k = 0; k < PAT_PAIRS; k++) begin
            if (k < int'(total)) begin
               store_in[2*k]   = (k < int'(beep_ctrl.nshort)) ? cfg.short_tone
                                                              : cfg.long_tone;
               store_in[2*k+1] = cfg.tone_gap;
            end
         end
         len_in  = pairs << 1;
         pos_ld  = '0;
         tone_ld = '0;
      end

      tone_in = (tone_ld == TICK_MAX) ? TICK_MAX : tone_ld + 16'd1;
      pos_in  = pos_ld;
      buzz_in = buzz_ff;
      entry   = store_in[pos_ld[PAT_IDX_W-1:0]];
      if (pos_ld < len_in && pos_ld < PAT_LEN_W'(PATTERN_DEPTH)) begin
         buzz_in = ~pos_ld[0];
         if (tone_in > 16'(entry)) begin
            pos_in  = pos_ld + PAT_LEN_W'(1);
            tone_in = '0;
         end
      end

      // Error status flips the buzzer on each fast interval.
      if (beep_ctrl.toggle) begin
         buzz_in = ~buzz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PATTERN_DEPTH; k++) begin
            if (k < 2 * RESET_BEEPS && k < 2 * PAT_PAIRS) begin
               store_ff[k] <= (k % 2 == 0) ? RESET_SHORT_TONE : RESET_TONE_GAP;
            end else begin
               store_ff[k] <= '0;
            end
         end
         len_ff  <= PAT_LEN_W'(2 * ((RESET_BEEPS < PAT_PAIRS) ? RESET_BEEPS : PAT_PAIRS));
         pos_ff  <= '0;
         tone_ff <= '0;
         buzz_ff <= 1'b0;
      end else if (step) begin
         store_ff <= store_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         tone_ff  <= tone_in;
         buzz_ff  <= buzz_in;
      end
   end

endmodule

`default_nettype wire

### rtl/spc_panel.sv
// Link supervision, button handling and lamp driver of the status panel controller.
// Depends on spc_pkg; drives the beeper through a beep_ctrl_type struct.
`default_nettype none

module spc_panel (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  spc_pkg::cfg_type       cfg,
   input  wire logic              message_valid,
   input  wire logic [2:0]        message_code,
   input  wire logic              green_pressed,
   input  wire logic              yellow_pressed,
   output spc_pkg::beep_ctrl_type beep_ctrl,
   output logic [2:0]             lamp_levels,
   output logic                   link_up,
   output logic [1:0]             host_command
);
   import spc_pkg::*;

   logic [31:0]    time_ff, time_in;
   logic [31:0]    last_ff, last_in;
   run_status_type status_ff, status_in;
   logic           conn_ff, conn_in;
   logic [9:0]     ghold_ff, ghold_in;
   logic [9:0]     yhold_ff, yhold_in;
   logic           gfired_ff, gfired_in;
   logic           yfired_ff, yfired_in;
   logic [2:0]     lamps_ff, lamps_in;
   logic [1:0]     rot_ff, rot_in;
   logic [15:0]    lticks_ff, lticks_in;
   host_cmd_type   cmd_ff, cmd_in;

   logic [31:0]    elapsed;
   logic [9:0]     ghold_cur, yhold_cur;
   logic           gfired_cur, yfired_cur;
   logic           fast_due, slow_due;

   assign lamp_levels  = lamps_ff;
   assign link_up      = conn_ff;
   assign host_command = cmd_ff;

   always_comb begin
      // Host message and link timeout.
      status_in = status_ff;
      conn_in   = conn_ff;
      last_in   = last_ff;
      if (message_valid) begin
         conn_in = 1'b1;
         if (message_code <= STATUS_ERROR) begin
            status_in = run_status_type'(message_code);
            last_in   = time_ff;
         end else begin
            last_in = '0;
         end
      end
      elapsed = time_ff - last_in;
      if (elapsed > {16'd0, cfg.disconnect_timeout}) begin
         conn_in = 1'b0;
      end

      // Link edges load the connect or disconnect beeps.
      beep_ctrl = '0;
      if (conn_in && !conn_ff) begin
         beep_ctrl.load   = 1'b1;
         beep_ctrl.nshort = 2'd2;
      end
      if (!conn_in && conn_ff) begin
         beep_ctrl.load  = 1'b1;
         beep_ctrl.nlong = 2'd3;
      end

      // Button holds; a released button clears its count and fired flag.
      ghold_cur  = green_pressed  ? ghold_ff  : '0;
      yhold_cur  = yellow_pressed ? yhold_ff  : '0;
      gfired_cur = green_pressed  && gfired_ff;
      yfired_cur = yellow_pressed && yfired_ff;
      gfired_in  = gfired_cur;
      yfired_in  = yfired_cur;
      cmd_in     = CMD_NONE;
      if (green_pressed && yellow_pressed && ghold_cur > cfg.chord_hold
          && yhold_cur > cfg.chord_hold && !gfired_cur && !yfired_cur) begin
         gfired_in        = 1'b1;
         yfired_in        = 1'b1;
         beep_ctrl.load   = 1'b1;
         beep_ctrl.nshort = 2'd0;
         beep_ctrl.nlong  = 2'd2;
         cmd_in           = CMD_STOP;
      end else if (green_pressed && ghold_cur > cfg.single_hold && !gfired_cur) begin
         gfired_in        = 1'b1;
         beep_ctrl.load   = 1'b1;
         beep_ctrl.nshort = 2'd1;
         beep_ctrl.nlong  = 2'd1;
         cmd_in           = CMD_START_A;
      end else if (yellow_pressed && yhold_cur > cfg.single_hold && !yfired_cur) begin
         yfired_in        = 1'b1;
         beep_ctrl.load   = 1'b1;
         beep_ctrl.nshort = 2'd2;
         beep_ctrl.nlong  = 2'd1;
         cmd_in           = CMD_START_B;
      end
      ghold_in = (green_pressed && ghold_cur != HOLD_MAX)  ? ghold_cur + 10'd1 : ghold_cur;
      yhold_in = (yellow_pressed && yhold_cur != HOLD_MAX) ? yhold_cur + 10'd1 : yhold_cur;

      // Lamp timing: rotation while the link is down, status display while up.
      lticks_in = (lticks_ff == TICK_MAX) ? TICK_MAX : lticks_ff + 16'd1;
      fast_due  = lticks_in > {6'd0, cfg.fast_blink};
      slow_due  = lticks_in > {6'd0, cfg.slow_blink};
      lamps_in  = lamps_ff;
      rot_in    = rot_ff;
      if (!conn_in) begin
         if (fast_due) begin
            if (rot_ff != 2'd3) begin
               lamps_in = lamps_ff ^ (3'd1 << rot_ff);
            end
            rot_in    = (rot_ff >= 2'd2) ? 2'd0 : rot_ff + 2'd1;
            lticks_in = '0;
         end
      end else begin
         case (status_in)
            STATUS_IDLE: begin
               if (slow_due) begin
                  lamps_in  = (lamps_ff & 3'b010) ^ 3'b010;
                  lticks_in = '0;
               end
            end
            STATUS_RUN_A: begin
               if (fast_due) begin
                  lamps_in  = (lamps_ff & 3'b001) ^ 3'b001;
                  lticks_in = '0;
               end
            end
            STATUS_RUN_B: begin
               if (fast_due) begin
                  lamps_in  = (lamps_ff & 3'b100) ^ 3'b100;
                  lticks_in = '0;
               end
            end
            STATUS_STOPPED: begin
               lamps_in = 3'b010;
            end
            STATUS_ERROR: begin
               if (fast_due) begin
                  lamps_in         = (lamps_ff & 3'b010) ^ 3'b010;
                  beep_ctrl.toggle = 1'b1;
                  lticks_in        = '0;
               end
            end
            default: begin
               lamps_in = lamps_ff;
            end
         endcase
      end

      time_in = time_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff   <= '0;
         last_ff   <= '0;
         status_ff <= STATUS_IDLE;
         conn_ff   <= 1'b0;
         ghold_ff  <= '0;
         yhold_ff  <= '0;
         gfired_ff <= 1'b0;
         yfired_ff <= 1'b0;
         lamps_ff  <= '0;
         rot_ff    <= '0;
         lticks_ff <= '0;
         cmd_ff    <= CMD_NONE;
      end else if (step) begin
         time_ff   <= time_in;
         last_ff   <= last_in;
         status_ff <= status_in;
         conn_ff   <= conn_in;
         ghold_ff  <= ghold_in;
         yhold_ff  <= yhold_in;
         gfired_ff <= gfired_in;
         yfired_ff <= yfired_in;
         lamps_ff  <= lamps_in;
         rot_ff    <= rot_in;
         lticks_ff <= lticks_in;
         cmd_ff    <= cmd_in;
      end
   end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for status_panel_controller: directed ticks, register extremes,
// random host sessions under back-pressure and a stopped stretch with button holds.
// Depends on spc_pkg and the status_panel_controller RTL.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spc_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 5;
   localparam int IDLE_LIMIT      = 1000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int PRINT_CAP       = 40;

   // Message codes beyond the run status set are not recognized by the panel.
   localparam logic [2:0] MSG_UNKNOWN_FIRST = 3'd5;
   localparam logic [2:0] MSG_UNKNOWN_LAST  = 3'd7;

   // Register values after reset that the package does not already provide.
   localparam logic [15:0] RESET_TIMEOUT     = 16'd1000;
   localparam logic [15:0] RESET_CHORD_HOLD  = 16'd100;
   localparam logic [15:0] RESET_SINGLE_HOLD = 16'd500;
   localparam logic [15:0] RESET_FAST_BLINK  = 16'd100;
   localparam logic [15:0] RESET_SLOW_BLINK  = 16'd500;

   typedef struct packed {
      logic       msg_valid;
      logic [2:0] code;
      logic       green;
      logic       yellow;
   } tick_t;

   typedef struct packed {
      logic         buzzer;
      logic         green;
      logic         red;
      logic         yellow;
      logic         link;
      host_cmd_type cmd;
   } panel_out_t;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_style_t;
   typedef enum {PRESS_NONE, PRESS_GREEN, PRESS_YELLOW, PRESS_BOTH, PRESS_NOISE} press_plan_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic                   req_message_valid  = 1'b0;
   logic [2:0]             req_message_code   = '0;
   logic                   req_green_pressed  = 1'b0;
   logic                   req_yellow_pressed = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic                   rsp_buzzer_on;
   logic                   rsp_lamp_green;
   logic                   rsp_lamp_red;
   logic                   rsp_lamp_yellow;
   logic                   rsp_link_up;
   logic [1:0]             rsp_host_command;
   logic                   csr_valid          = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_data           = '0;

   status_panel_controller uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_message_valid  (req_message_valid),
      .req_message_code   (req_message_code),
      .req_green_pressed  (req_green_pressed),
      .req_yellow_pressed (req_yellow_pressed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_buzzer_on      (rsp_buzzer_on),
      .rsp_lamp_green     (rsp_lamp_green),
      .rsp_lamp_red       (rsp_lamp_red),
      .rsp_lamp_yellow    (rsp_lamp_yellow),
      .rsp_link_up        (rsp_link_up),
      .rsp_host_command   (rsp_host_command),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Panel state as the predictor sees it.
   logic [15:0]          panel_cfg [8];
   logic [31:0]          clk_ms;
   logic [31:0]          last_msg_ms;
   run_status_type       status;
   logic                 link;
   logic                 link_before;
   logic [8:0]           beep_store [PATTERN_DEPTH];
   logic [PAT_LEN_W-1:0] beep_len;
   logic [PAT_LEN_W-1:0] beep_pos;
   logic [15:0]          tone_ticks;
   logic                 buzzer;
   logic [2:0]           lamps;
   logic [1:0]           rot_pos;
   logic [15:0]          lamp_ticks;
   logic [9:0]           green_hold;
   logic [9:0]           yellow_hold;
   logic                 green_fired;
   logic                 yellow_fired;

   // Bookkeeping shared by the stimulus and the response check.
   panel_out_t   expected_panel_q [$];
   int           error_count       = 0;
   int           ticks_sent        = 0;
   int           responses_checked = 0;
   int           csr_writes        = 0;
   int           idle_cycles       = 0;
   int           burst_left        = 0;
   bit           steady_sender     = 1'b0;
   int           hold_off_left     = 0;
   stall_style_t stall_style       = STALL_NONE;
   logic [5:0]   stall_phase       = '0;

   // Load a beep pattern of short beeps then long beeps, each followed by a gap.
   function automatic void load_beeps(input int n_short, input int n_long);
      int i;
      for (i = 0; i < n_short + n_long && 2 * i + 1 < PATTERN_DEPTH; i++) begin
         beep_store[2 * i] = (i < n_short) ? panel_cfg[CSR_SHORT_TONE][8:0]
                                           : panel_cfg[CSR_LONG_TONE][8:0];
         beep_store[2 * i + 1] = panel_cfg[CSR_TONE_GAP][8:0];
      end
      beep_len   = PAT_LEN_W'(2 * i);
      beep_pos   = '0;
      tone_ticks = '0;
   endfunction

   // Toggle one lamp on its own: if it was lit, everything goes dark.
   function automatic void show_lamp(input int bit_pos);
      logic [2:0] keep;
      keep  = 3'b001 << bit_pos;
      lamps = (lamps & keep) ^ keep;
   endfunction

   function automatic void restore_panel_defaults();
      panel_cfg[CSR_DISCONNECT_TIMEOUT] = RESET_TIMEOUT;
      panel_cfg[CSR_CHORD_HOLD]         = RESET_CHORD_HOLD;
      panel_cfg[CSR_SINGLE_HOLD]        = RESET_SINGLE_HOLD;
      panel_cfg[CSR_SHORT_TONE]         = {7'd0, RESET_SHORT_TONE};
      panel_cfg[CSR_LONG_TONE]          = {7'd0, RESET_LONG_TONE};
      panel_cfg[CSR_TONE_GAP]           = {7'd0, RESET_TONE_GAP};
      panel_cfg[CSR_FAST_BLINK]         = RESET_FAST_BLINK;
      panel_cfg[CSR_SLOW_BLINK]         = RESET_SLOW_BLINK;
      clk_ms       = '0;
      last_msg_ms  = '0;
      status       = STATUS_IDLE;
      link         = 1'b0;
      link_before  = 1'b0;
      foreach (beep_store[i]) beep_store[i] = '0;
      load_beeps(RESET_BEEPS, 0);
      buzzer       = 1'b0;
      lamps        = '0;
      rot_pos      = '0;
      lamp_ticks   = '0;
      green_hold   = '0;
      yellow_hold  = '0;
      green_fired  = 1'b0;
      yellow_fired = 1'b0;
   endfunction

   // Advance the panel by one tick and return the levels it shows afterwards.
   function automatic panel_out_t advance_panel(input tick_t t);
      panel_out_t   o;
      logic [31:0]  now;
      host_cmd_type cmd;
      now = clk_ms;
      cmd = CMD_NONE;

      // Host message and link supervision.
      if (t.msg_valid) begin
         link        = 1'b1;
         last_msg_ms = now;
         if (t.code <= STATUS_ERROR) status = run_status_type'(t.code);
         else last_msg_ms = '0;
      end
      if (now - last_msg_ms > {16'd0, panel_cfg[CSR_DISCONNECT_TIMEOUT]}) link = 1'b0;
      if (link && !link_before) load_beeps(2, 0);
      if (!link && link_before) load_beeps(0, 3);
      link_before = link;

      // Button holds: a chord sends stop, a single long hold sends a start.
      if (!t.green) begin
         green_hold  = '0;
         green_fired = 1'b0;
      end
      if (!t.yellow) begin
         yellow_hold  = '0;
         yellow_fired = 1'b0;
      end
      if (t.green && t.yellow && green_hold > panel_cfg[CSR_CHORD_HOLD]
          && yellow_hold > panel_cfg[CSR_CHORD_HOLD] && !green_fired && !yellow_fired) begin
         green_fired  = 1'b1;
         yellow_fired = 1'b1;
         load_beeps(0, 2);
         cmd = CMD_STOP;
      end else if (t.green && green_hold > panel_cfg[CSR_SINGLE_HOLD] && !green_fired) begin
         green_fired = 1'b1;
         load_beeps(1, 1);
         cmd = CMD_START_A;
      end else if (t.yellow && yellow_hold > panel_cfg[CSR_SINGLE_HOLD] && !yellow_fired) begin
         yellow_fired = 1'b1;
         load_beeps(2, 1);
         cmd = CMD_START_B;
      end

      // Beep pattern: even entries are tones, odd entries are gaps.
      if (tone_ticks != TICK_MAX) tone_ticks++;
      if (beep_pos < beep_len && beep_pos < PATTERN_DEPTH) begin
         buzzer = (beep_pos[0] == 1'b0);
         if (tone_ticks > beep_store[beep_pos]) begin
            beep_pos++;
            tone_ticks = '0;
         end
      end

      // Lamps rotate green, red, yellow while the link is down.
      if (lamp_ticks != TICK_MAX) lamp_ticks++;
      if (!link) begin
         if (lamp_ticks > panel_cfg[CSR_FAST_BLINK]) begin
            case (rot_pos)
               2'd0: lamps[LAMP_G_BIT] = ~lamps[LAMP_G_BIT];
               2'd1: lamps[LAMP_R_BIT] = ~lamps[LAMP_R_BIT];
               2'd2: lamps[LAMP_Y_BIT] = ~lamps[LAMP_Y_BIT];
               default: ;
            endcase
            rot_pos    = (rot_pos == 2'd2) ? 2'd0 : rot_pos + 2'd1;
            lamp_ticks = '0;
         end
      end else begin
         case (status)
            STATUS_IDLE: if (lamp_ticks > panel_cfg[CSR_SLOW_BLINK]) begin
               show_lamp(LAMP_R_BIT);
               lamp_ticks = '0;
            end
            STATUS_RUN_A: if (lamp_ticks > panel_cfg[CSR_FAST_BLINK]) begin
               show_lamp(LAMP_G_BIT);
               lamp_ticks = '0;
            end
            STATUS_RUN_B: if (lamp_ticks > panel_cfg[CSR_FAST_BLINK]) begin
               show_lamp(LAMP_Y_BIT);
               lamp_ticks = '0;
            end
            STATUS_STOPPED: lamps = 3'b001 << LAMP_R_BIT;
            STATUS_ERROR: if (lamp_ticks > panel_cfg[CSR_FAST_BLINK]) begin
               show_lamp(LAMP_R_BIT);
               buzzer     = ~buzzer;
               lamp_ticks = '0;
            end
            default: ;
         endcase
      end

      if (t.green && green_hold != HOLD_MAX) green_hold++;
      if (t.yellow && yellow_hold != HOLD_MAX) yellow_hold++;
      clk_ms = now + 32'd1;

      o.buzzer = buzzer;
      o.green  = lamps[LAMP_G_BIT];
      o.red    = lamps[LAMP_R_BIT];
      o.yellow = lamps[LAMP_Y_BIT];
      o.link   = link;
      o.cmd    = cmd;
      return o;
   endfunction

   task automatic check_field(input string what, input logic [1:0] want, input logic [1:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= PRINT_CAP)
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // Responses are sampled mid-cycle and taken at the following rising edge.
   always @(negedge clock) begin : watch_responses
      panel_out_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_panel_q.size() == 0) begin
            error_count++;
            if (error_count <= PRINT_CAP)
               $display("%0t: response with no request outstanding", $time);
         end else begin
            want = expected_panel_q.pop_front();
            check_field("buzzer_on", want.buzzer, rsp_buzzer_on);
            check_field("lamp_green", want.green, rsp_lamp_green);
            check_field("lamp_red", want.red, rsp_lamp_red);
            check_field("lamp_yellow", want.yellow, rsp_lamp_yellow);
            check_field("link_up", want.link, rsp_link_up);
            check_field("host_command", want.cmd, rsp_host_command);
            responses_checked++;
         end
      end

      // Watchdog: any handshake on any channel counts as progress.
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("status_panel_controller verification failed");
            $finish;
         end
      end
   end

   // Receiver back-pressure: a long hold-off when asked, otherwise the chosen style.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 6'd1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left != 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         case (stall_style)
            STALL_RANDOM:  rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_PATTERN: rsp_stall <= (stall_phase[2:0] == 3'd3) || (stall_phase[5:3] == 3'd6);
            default:       rsp_stall <= 1'b0;
         endcase
      end
   end

   // Offer one tick request; the sender works in bursts separated by random gaps, none when steady.
   task automatic send_tick(input tick_t t);
      int   gap;
      logic taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady_sender ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_message_valid  <= t.msg_valid;
      req_message_code   <= t.code;
      req_green_pressed  <= t.green;
      req_yellow_pressed <= t.yellow;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      expected_panel_q.push_back(advance_panel(t));
      ticks_sent++;
   endtask

   task automatic send_item(input logic m, input logic [2:0] c, input logic g, input logic y);
      tick_t t;
      t.msg_valid = m;
      t.code      = c;
      t.green     = g;
      t.yellow    = y;
      send_tick(t);
   endtask

   // Stop offering requests and wait until every outstanding response is back.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_panel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      logic taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      // Each register keeps only its own width; indexes past the file are dropped.
      case (idx)
         CSR_DISCONNECT_TIMEOUT: panel_cfg[idx] = data;
         CSR_CHORD_HOLD, CSR_SINGLE_HOLD, CSR_FAST_BLINK, CSR_SLOW_BLINK:
            panel_cfg[idx] = data & 16'h03FF;
         CSR_SHORT_TONE, CSR_LONG_TONE, CSR_TONE_GAP:
            panel_cfg[idx] = data & 16'h01FF;
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Reprogram every register once the block is idle, plus one stray index.
   task automatic program_panel(input logic [15:0] timeout_v, chord_v, single_v, short_v,
                                input logic [15:0] long_v, gap_v, fast_v, slow_v);
      logic [CSR_INDEX_W-1:0] stray;
      settle_block();
      write_csr(CSR_DISCONNECT_TIMEOUT, timeout_v);
      write_csr(CSR_CHORD_HOLD, chord_v);
      write_csr(CSR_SINGLE_HOLD, single_v);
      write_csr(CSR_SHORT_TONE, short_v);
      write_csr(CSR_LONG_TONE, long_v);
      write_csr(CSR_TONE_GAP, gap_v);
      write_csr(CSR_FAST_BLINK, fast_v);
      write_csr(CSR_SLOW_BLINK, slow_v);
      stray = {1'b1, 3'($urandom)};
      write_csr(stray, 16'($urandom));
   endtask

   // Random host sessions: stretches of message traffic with button holds of varied length,
   // some broken holds and some pure noise.
   task automatic run_sessions(input int n_items);
      int          sent;
      int          seg_len;
      int          msg_pct;
      int          span;
      int          i;
      press_plan_t plan;
      tick_t       t;
      sent = 0;
      span = (panel_cfg[CSR_SINGLE_HOLD] < 40) ? panel_cfg[CSR_SINGLE_HOLD] + 12 : 52;
      while (sent < n_items) begin
         seg_len = $urandom_range(2, span);
         case ($urandom_range(0, 3))
            0:       msg_pct = 0;
            1:       msg_pct = 5;
            2:       msg_pct = 30;
            default: msg_pct = 90;
         endcase
         plan = press_plan_t'($urandom_range(PRESS_NONE, PRESS_NOISE));
         for (i = 0; i < seg_len && sent < n_items; i++) begin
            t.msg_valid = ($urandom_range(0, 99) < msg_pct);
            if ($urandom_range(0, 9) == 0)
               t.code = 3'($urandom_range(MSG_UNKNOWN_FIRST, MSG_UNKNOWN_LAST));
            else
               t.code = 3'($urandom_range(STATUS_IDLE, STATUS_ERROR));
            t.green  = (plan == PRESS_GREEN) || (plan == PRESS_BOTH);
            t.yellow = (plan == PRESS_YELLOW) || (plan == PRESS_BOTH);
            if (plan == PRESS_NOISE) t = 6'($urandom);
            else if ($urandom_range(0, 29) == 0) t.green = !t.green;
            else if ($urandom_range(0, 29) == 0) t.yellow = !t.yellow;
            send_tick(t);
            sent++;
         end
      end
   endtask

   // Every message code, chord stop, both starts, and a link edge in the tick a start fires.
   task automatic test_directed();
      int c;
      send_item(1'b0, STATUS_IDLE, 1'b0, 1'b0);
      send_item(1'b0, STATUS_IDLE, 1'b0, 1'b0);
      program_panel(16'd3, 16'd1, 16'd2, 16'd1, 16'd2, 16'd0, 16'd1, 16'd2);
      stall_style <= STALL_RANDOM;
      for (c = STATUS_IDLE; c <= STATUS_ERROR; c++) send_item(1'b1, 3'(c), 1'b0, 1'b0);
      for (c = MSG_UNKNOWN_FIRST; c <= MSG_UNKNOWN_LAST; c++)
         send_item(1'b1, 3'(c), 1'b1, 1'b1);
      repeat (2) send_item(1'b0, STATUS_IDLE, 1'b1, 1'b1);
      send_item(1'b0, STATUS_IDLE, 1'b0, 1'b0);
      repeat (4) send_item(1'b0, STATUS_IDLE, 1'b1, 1'b0);
      repeat (4) send_item(1'b0, STATUS_IDLE, 1'b0, 1'b1);
      repeat (3) send_item(1'b0, STATUS_IDLE, 1'b1, 1'b0);
      send_item(1'b1, STATUS_RUN_A, 1'b1, 1'b0);
   endtask

   // Minimum, maximum and out-of-range register settings, including masked upper bits.
   task automatic test_register_extremes();
      steady_sender = 1'b0;
      stall_style <= STALL_RANDOM;
      program_panel(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_sessions(35);
      program_panel(16'd1, 16'hFFFF, 16'hFFFF, 16'd511, 16'd511, 16'd511, 16'd1022, 16'd1022);
      run_sessions(35);
      program_panel(16'hFFFF, 16'd1022, 16'd1022, 16'hFE05, 16'hFFFF, 16'hFE03, 16'hFFFF, 16'd0);
      run_sessions(35);
      program_panel(16'd2, 16'd0, 16'd1, 16'd511, 16'd0, 16'd0, 16'd0, 16'd1022);
      run_sessions(35);
   endtask

   // Random sessions with small random settings; one long receiver hold-off and one
   // full drain pause by the sender.
   task automatic test_random_sessions();
      int phase;
      for (phase = 0; phase < 5; phase++) begin
         program_panel(16'($urandom_range(1, 40)), 16'($urandom_range(0, 20)),
                       16'($urandom_range(0, 24)), 16'($urandom_range(0, 15)),
                       16'($urandom_range(0, 20)), 16'($urandom_range(0, 8)),
                       16'($urandom_range(0, 20)), 16'($urandom_range(0, 30)));
         steady_sender = (phase % 2 == 1);
         stall_style <= stall_style_t'(phase % 3);
         if (phase == 1) begin
            run_sessions(30);
            hold_off_left <= HOLD_OFF_CYCLES;
            run_sessions(70);
         end else if (phase == 3) begin
            run_sessions(50);
            settle_block();
            run_sessions(50);
         end else begin
            run_sessions(90);
         end
      end
   endtask

   // Stopped status with a green hold, a yellow hold and a chord, then idle blinking.
   task automatic test_stopped_and_idle();
      int i;
      program_panel(16'hFFFF, 16'd20, 16'd30, 16'd2, 16'd3, 16'd1, 16'd5, 16'd12);
      steady_sender = 1'b1;
      stall_style <= STALL_PATTERN;
      for (i = 0; i < 130; i++) begin
         send_item(i % 45 == 0, STATUS_STOPPED,
                   (i >= 5 && i < 45) || (i >= 95 && i < 125),
                   (i >= 50 && i < 90) || (i >= 95 && i < 125));
      end
      for (i = 0; i < 30; i++) send_item(i % 15 == 0, STATUS_IDLE, 1'b0, 1'b0);
   endtask

   initial begin
      restore_panel_defaults();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_random_sessions();
      test_stopped_and_idle();
      settle_block();
      $display("Covered %0d ticks with %0d responses checked and %0d register writes,",
               ticks_sent, responses_checked, csr_writes);
      $display("spanning link loss, button chords and holds, error blinking and back-pressure.");
      if (error_count == 0 && expected_panel_q.size() == 0)
         $display("status_panel_controller verification clean");
      else
         $display("status_panel_controller verification failed");
      $finish;
   end

endmodule
